// ----- hw/rtl/binary_closing_diamond5_macros.svh -----
// ----------------------------------------------------------------------------
// binary_closing_diamond5 assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_CLOSING_DIAMOND5_MACROS_SVH
`define BINARY_CLOSING_DIAMOND5_MACROS_SVH

// same-cycle implication, off during reset
`define BCD5_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define BCD5_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also checks through reset
`define BCD5_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bcd5_pkg.sv -----
// ----------------------------------------------------------------------------
// bcd5_pkg
// Types and constants of the 5x5 diamond binary closing block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcd5_pkg;

  localparam int KERNEL = 5;

  // configuration port
  localparam int ADDR_W  = 4;
  localparam int CFG_W   = 11;

  localparam logic [1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [7:0]       THRESHOLD_RST    = 8'd128;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // output pixel levels
  localparam logic [7:0] PIX_FG = 8'd0;
  localparam logic [7:0] PIX_BG = 8'd255;

  // diamond taps, symmetric in both axes
  localparam logic [KERNEL-1:0][KERNEL-1:0] DIAMOND = {
    5'b00100,
    5'b01110,
    5'b11111,
    5'b01110,
    5'b00100
  };

  typedef struct packed {
    logic       command;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       end_of_frame;
  } out_item_t;

endpackage

// ----- hw/rtl/binary_closing_diamond5.sv -----
// Streaming 5x5 diamond closing of a thresholded grayscale frame.
// Input channel (in_valid/in_ready/in_data) takes one item per cycle when not
// stalled: a pixel in raster order, or a flush tick that pushes out the tail of the frame.
// Output channel (out_valid/out_ready/out_data) gives the closed pixel,
// 0 for foreground and 255 for background, with end_of_frame on the last one.
// The result of pixel k comes with the item at position k+4W+4 and shows on
// out_valid once that item has passed the window stage and the output register.
// Throughput is one item per cycle while the receiver keeps up; each item reads and writes one column of
// both line memories, which is what sets the rate.
// Flush ticks inside the frame are taken and dropped; pixels sent after the
// last frame pixel act as flush ticks.
// When the receiver stalls, one result waits in the output register and one
// more item is held in the window stage; in_ready then drops.
// Reset (rst_n low, synchronous) empties the pipeline, restores threshold 128
// and a 640x480 frame, and starts at the first pixel; line memories need no
// clearing. Writing frame_width or frame_height restarts the frame.
// Registers on the APB port: threshold at 0x0, frame_width at 0x4,
// frame_height at 0x8.
// ----------------------------------------------------------------------------
// binary_closing_diamond5
// Threshold, dilate and erode with a 5x5 diamond over a pixel stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_closing_diamond5 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bcd5_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bcd5_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcd5_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int K  = bcd5_pkg::KERNEL;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int RW = $clog2(MAX_HEIGHT) + 2;
  localparam int HW = RW - 1;

  // configuration
  logic [7:0]                 thr_r;
  logic [bcd5_pkg::CFG_W-1:0] fw_r;
  logic [bcd5_pkg::CFG_W-1:0] fh_r;
  logic                       cfg_wr;
  logic [1:0]                 cfg_idx;
  logic                       geom_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[bcd5_pkg::ADDR_W-1:2];
  assign geom_wr = cfg_wr && ((cfg_idx == bcd5_pkg::REG_FRAME_WIDTH) ||
                              (cfg_idx == bcd5_pkg::REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= bcd5_pkg::THRESHOLD_RST;
      fw_r  <= bcd5_pkg::FRAME_WIDTH_RST;
      fh_r  <= bcd5_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bcd5_pkg::REG_THRESHOLD:    thr_r <= pwdata[7:0];
        bcd5_pkg::REG_FRAME_WIDTH:  fw_r  <= pwdata[bcd5_pkg::CFG_W-1:0];
        bcd5_pkg::REG_FRAME_HEIGHT: fh_r  <= pwdata[bcd5_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      bcd5_pkg::REG_THRESHOLD:    prdata = 32'(thr_r);
      bcd5_pkg::REG_FRAME_WIDTH:  prdata = 32'(fw_r);
      bcd5_pkg::REG_FRAME_HEIGHT: prdata = 32'(fh_r);
      default:                    prdata = '0;
    endcase
  end

  // clamped geometry
  logic [WW-1:0]        w_eff;
  logic [HW-1:0]        h_eff;
  logic signed [RW-1:0] h_s;
  logic [CW-1:0]        w_last;

  always_comb begin
    if (fw_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(fw_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_r);
    end
    if (fh_r == '0) begin
      h_eff = HW'(1);
    end else if (int'(fh_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(fh_r);
    end
  end

  assign h_s    = $signed({1'b0, h_eff});
  assign w_last = CW'(w_eff - WW'(1));

  // start positions of the dilation and output points, 2W+2 and 4W+4 behind
  logic signed [RW-1:0] d_row_init;
  logic [CW-1:0]        d_col_init;
  logic signed [RW-1:0] o_row_init;
  logic [CW-1:0]        o_col_init;

  always_comb begin
    if (w_eff >= WW'(2)) begin
      d_row_init = RW'(-3);
      d_col_init = CW'(w_eff - WW'(2));
    end else begin
      d_row_init = RW'(-4);
      d_col_init = '0;
    end
    if (w_eff >= WW'(4)) begin
      o_row_init = RW'(-5);
      o_col_init = CW'(w_eff - WW'(4));
    end else if (w_eff == WW'(3)) begin
      o_row_init = RW'(-6);
      o_col_init = CW'(2);
    end else if (w_eff == WW'(2)) begin
      o_row_init = RW'(-6);
      o_col_init = '0;
    end else begin
      o_row_init = RW'(-8);
      o_col_init = '0;
    end
  end

  // position counters; pending means the next step starts a frame
  logic                 pending_r;
  logic [RW-1:0]        in_row_r;
  logic [CW-1:0]        in_col_r;
  logic signed [RW-1:0] d_row_r;
  logic [CW-1:0]        d_col_r;
  logic signed [RW-1:0] o_row_r;
  logic [CW-1:0]        o_col_r;

  logic [RW-1:0]        in_row_c;
  logic [CW-1:0]        in_col_c;
  logic signed [RW-1:0] d_row_c;
  logic [CW-1:0]        d_col_c;
  logic signed [RW-1:0] o_row_c;
  logic [CW-1:0]        o_col_c;

  logic [RW-1:0]        in_row_nxt;
  logic [CW-1:0]        in_col_nxt;
  logic signed [RW-1:0] d_row_nxt;
  logic [CW-1:0]        d_col_nxt;
  logic signed [RW-1:0] o_row_nxt;
  logic [CW-1:0]        o_col_nxt;

  always_comb begin
    in_row_c = pending_r ? '0 : in_row_r;
    in_col_c = pending_r ? '0 : in_col_r;
    d_row_c  = pending_r ? d_row_init : d_row_r;
    d_col_c  = pending_r ? d_col_init : d_col_r;
    o_row_c  = pending_r ? o_row_init : o_row_r;
    o_col_c  = pending_r ? o_col_init : o_col_r;
  end

  always_comb begin
    if (in_col_c == w_last) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_c + RW'(1);
    end else begin
      in_col_nxt = in_col_c + CW'(1);
      in_row_nxt = in_row_c;
    end
    if (d_col_c == w_last) begin
      d_col_nxt = '0;
      d_row_nxt = d_row_c + RW'(1);
    end else begin
      d_col_nxt = d_col_c + CW'(1);
      d_row_nxt = d_row_c;
    end
    if (o_col_c == w_last) begin
      o_col_nxt = '0;
      o_row_nxt = o_row_c + RW'(1);
    end else begin
      o_col_nxt = o_col_c + CW'(1);
      o_row_nxt = o_row_c;
    end
  end

  // accept side
  logic in_fire;
  logic in_frame;
  logic step;
  logic new_bit;
  logic o_live;
  logic eof_c;
  logic s1_fire;

  assign in_fire  = in_valid && in_ready;
  assign in_frame = in_row_c < {1'b0, h_eff};
  // a flush tick inside the frame is taken and dropped
  assign step     = in_fire && !(in_frame && (in_data.command == bcd5_pkg::CMD_FLUSH));
  assign new_bit  = in_frame && (in_data.pixel_in <= thr_r);
  assign o_live   = !o_row_c[RW-1];
  assign eof_c    = o_live && (o_row_c == (h_s - RW'(1))) && (o_col_c == w_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b1;
      in_row_r  <= '0;
      in_col_r  <= '0;
      d_row_r   <= '0;
      d_col_r   <= '0;
      o_row_r   <= '0;
      o_col_r   <= '0;
    end else if (geom_wr) begin
      pending_r <= 1'b1;
    end else if (step) begin
      pending_r <= eof_c;
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      d_row_r   <= d_row_nxt;
      d_col_r   <= d_col_nxt;
      o_row_r   <= o_row_nxt;
      o_col_r   <= o_col_nxt;
    end
  end

  // window stage
  logic                 s1_valid_r;
  logic                 s1_bit_r;
  logic [CW-1:0]        s1_x_r;
  logic signed [RW-1:0] s1_dr_r;
  logic [CW-1:0]        s1_dc_r;
  logic signed [RW-1:0] s1_ro_r;
  logic [CW-1:0]        s1_co_r;
  logic                 s1_live_r;
  logic                 s1_eof_r;

  // line memories: each word holds the four rows above, newest in bit 0
  logic [K-2:0] bmem [MAX_WIDTH];
  logic [K-2:0] dmem [MAX_WIDTH];
  logic [K-2:0] brd_r;
  logic [K-2:0] drd_r;
  logic [K-2:0] bmem_wdata;
  logic [K-2:0] dmem_wdata;

  // previous four columns of each image, index 0 is the most recent
  logic [K-2:0][K-1:0] bwin_r;
  logic [K-2:0][K-1:0] dwin_r;
  logic [K-1:0][K-1:0] bfull;
  logic [K-1:0][K-1:0] dfull;

  logic [K-1:0]         d_rok;
  logic [K-1:0]         d_cok;
  logic [K-1:0]         e_rok;
  logic [K-1:0]         e_cok;
  logic signed [RW-1:0] d_rpos [K];
  logic signed [RW-1:0] e_rpos [K];
  logic signed [CW+1:0] d_cpos [K];
  logic signed [CW+1:0] e_cpos [K];
  logic signed [CW+1:0] w_s;
  logic                 dbit;
  logic                 ebit;

  assign w_s = $signed({1'b0, w_eff});

  // bit k of a column is row 2-k below the center, column m is 2-m right
  always_comb begin
    for (int k = 0; k < K; k++) begin
      d_rpos[k] = s1_dr_r + $signed(RW'(2 - k));
      e_rpos[k] = s1_ro_r + $signed(RW'(2 - k));
      d_rok[k]  = !d_rpos[k][RW-1] && (d_rpos[k] < h_s);
      e_rok[k]  = !e_rpos[k][RW-1] && (e_rpos[k] < h_s);
    end
    for (int m = 0; m < K; m++) begin
      d_cpos[m] = $signed({2'b00, s1_dc_r}) + $signed((CW+2)'(2 - m));
      e_cpos[m] = $signed({2'b00, s1_co_r}) + $signed((CW+2)'(2 - m));
      d_cok[m]  = !d_cpos[m][CW+1] && (d_cpos[m] < w_s);
      e_cok[m]  = !e_cpos[m][CW+1] && (e_cpos[m] < w_s);
    end
  end

  always_comb begin
    bfull[0] = {brd_r, s1_bit_r};
    for (int m = 1; m < K; m++) begin
      bfull[m] = bwin_r[m-1];
    end
    // dilation: background beyond the border
    dbit = 1'b0;
    for (int k = 0; k < K; k++) begin
      for (int m = 0; m < K; m++) begin
        if (bcd5_pkg::DIAMOND[k][m] && d_rok[k] && d_cok[m] && bfull[m][k]) begin
          dbit = 1'b1;
        end
      end
    end
    dfull[0] = {drd_r, dbit};
    for (int m = 1; m < K; m++) begin
      dfull[m] = dwin_r[m-1];
    end
    // erosion: foreground beyond the border
    ebit = 1'b1;
    for (int k = 0; k < K; k++) begin
      for (int m = 0; m < K; m++) begin
        if (bcd5_pkg::DIAMOND[k][m] && e_rok[k] && e_cok[m] && !dfull[m][k]) begin
          ebit = 1'b0;
        end
      end
    end
  end

  assign bmem_wdata = {brd_r[K-3:0], s1_bit_r};
  assign dmem_wdata = {drd_r[K-3:0], dbit};

  logic                out_valid_r;
  bcd5_pkg::out_item_t out_data_r;

  assign s1_fire  = s1_valid_r && (!s1_live_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (step) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_bit_r  <= new_bit;
      s1_x_r    <= in_col_c;
      s1_dr_r   <= d_row_c;
      s1_dc_r   <= d_col_c;
      s1_ro_r   <= o_row_c;
      s1_co_r   <= o_col_c;
      s1_live_r <= o_live;
      s1_eof_r  <= eof_c;
      // bypass the column being written back in the same cycle
      brd_r     <= (s1_fire && (s1_x_r == in_col_c)) ? bmem_wdata : bmem[in_col_c];
      drd_r     <= (s1_fire && (s1_dc_r == d_col_c)) ? dmem_wdata : dmem[d_col_c];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      bmem[s1_x_r]  <= bmem_wdata;
      dmem[s1_dc_r] <= dmem_wdata;
      bwin_r[0]     <= {brd_r, s1_bit_r};
      dwin_r[0]     <= {drd_r, dbit};
      for (int i = 1; i < K - 1; i++) begin
        bwin_r[i] <= bwin_r[i-1];
        dwin_r[i] <= dwin_r[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_live_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_live_r) begin
      out_data_r.pixel_out    <= ebit ? bcd5_pkg::PIX_FG : bcd5_pkg::PIX_BG;
      out_data_r.end_of_frame <= s1_eof_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/bcd5_checker.sv -----
// ----------------------------------------------------------------------------
// bcd5_checker
// Port-level assertions for binary_closing_diamond5, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_closing_diamond5_macros.svh"

module bcd5_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bcd5_pkg::out_item_t out_data
);

  `BCD5_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")

  `BCD5_ASSERT_IMP(a_pix_code, out_valid, (out_data.pixel_out == bcd5_pkg::PIX_FG) || (out_data.pixel_out == bcd5_pkg::PIX_BG), "pixel_out is neither foreground nor background")

  // input side only backs up when a result is stuck at the output
  `BCD5_ASSERT_IMP(a_backpressure, !in_ready, out_valid && !out_ready, "in_ready low without a stalled result")

  `BCD5_ASSERT_RST(a_reset_empty, !rst_n, !out_valid && in_ready, "pipeline not empty after reset")

endmodule

bind binary_closing_diamond5 bcd5_checker u_bcd5_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- sim/tb_binary_closing_diamond5.sv -----
// ----------------------------------------------------------------------------
// tb_binary_closing_diamond5
// Self-checking bench for the 5x5 diamond closing block. Thresholds, dilates
// and erodes every frame in a small model of its own, and compares each output
// item in order. Runs a directed frame, geometry extremes, then random frames
// with noise and random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_binary_closing_diamond5;
  import bcd5_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 1024;
  localparam int RANDOM_ITEMS  = 1450;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 3000000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  int burst_left;
  int n_writes;
  int cycles;

  binary_closing_diamond5 #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // closing model plus the queue of pixels still owed by the block
  class closing_checker;
    int        thr;
    int        width_reg;
    int        height_reg;
    bit        bin_lines [8][MAX_W];
    bit        dil_lines [8][MAX_W];
    int        row;
    int        col;
    out_item_t expected_pixels [$];
    int        errors;
    int        n_items;
    int        n_results;
    int        n_frames;

    function new();
      thr        = THRESHOLD_RST;
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
    endfunction

    function int eff_w();
      if (width_reg < 1) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int eff_h();
      if (height_reg < 1) return 1;
      if (height_reg > MAX_H) return MAX_H;
      return height_reg;
    endfunction

    function longint frame_total();
      return longint'(eff_w()) * eff_h();
    endfunction

    function longint frame_pos();
      return longint'(row) * eff_w() + col;
    endfunction

    // items from the first pixel to the item that carries end_of_frame
    function longint frame_span();
      return frame_total() + 4 * eff_w() + 4;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_THRESHOLD: thr = value[7:0];
        REG_FRAME_WIDTH: begin
          width_reg = value[10:0];
          row = 0;
          col = 0;
        end
        REG_FRAME_HEIGHT: begin
          height_reg = value[10:0];
          row = 0;
          col = 0;
        end
        default: ;
      endcase
    endfunction

    // outside the frame dilation sees background
    function bit dilated(int r, int c, int w, int h);
      int rr;
      int cc;
      for (int dr = -2; dr <= 2; dr++) begin
        for (int dc = -2; dc <= 2; dc++) begin
          rr = r + dr;
          cc = c + dc;
          if ((dr < 0 ? -dr : dr) + (dc < 0 ? -dc : dc) <= 2 &&
              rr >= 0 && rr < h && cc >= 0 && cc < w && bin_lines[rr & 7][cc])
            return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // outside the frame erosion sees foreground
    function bit eroded(int r, int c, int w, int h);
      int rr;
      int cc;
      for (int dr = -2; dr <= 2; dr++) begin
        for (int dc = -2; dc <= 2; dc++) begin
          rr = r + dr;
          cc = c + dc;
          if ((dr < 0 ? -dr : dr) + (dc < 0 ? -dc : dc) <= 2 &&
              rr >= 0 && rr < h && cc >= 0 && cc < w && !dil_lines[rr & 7][cc])
            return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void take_item(in_item_t it);
      int        w;
      int        h;
      longint    total;
      longint    t;
      longint    d;
      longint    o;
      out_item_t e;
      w     = eff_w();
      h     = eff_h();
      total = longint'(w) * h;
      t     = longint'(row) * w + col;
      n_items++;
      if (t < total) begin
        // flush inside the frame is dropped
        if (it.command == CMD_FLUSH) return;
        bin_lines[row & 7][col] = (it.pixel_in <= thr);
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
      d = t - (2 * w + 2);
      if (d >= 0 && d < total)
        dil_lines[int'(d / w) & 7][int'(d % w)] = dilated(int'(d / w), int'(d % w), w, h);
      o = t - (4 * w + 4);
      if (o >= 0 && o < total) begin
        e.pixel_out    = eroded(int'(o / w), int'(o % w), w, h) ? PIX_FG : PIX_BG;
        e.end_of_frame = (o == total - 1);
        expected_pixels.push_back(e);
        if (o == total - 1) begin
          row = 0;
          col = 0;
        end
      end
    endfunction

    task flag(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_pixel(out_item_t got);
      out_item_t e;
      n_results++;
      if (expected_pixels.size() == 0) begin
        flag($sformatf("output item %0d with nothing pending", n_results));
        return;
      end
      e = expected_pixels.pop_front();
      if (got.pixel_out !== e.pixel_out)
        flag($sformatf("item %0d pixel_out 0x%0h, want 0x%0h",
                       n_results, got.pixel_out, e.pixel_out));
      if (got.end_of_frame !== e.end_of_frame)
        flag($sformatf("item %0d end_of_frame %0b, want %0b",
                       n_results, got.end_of_frame, e.end_of_frame));
      if (e.end_of_frame) n_frames++;
    endtask
  endclass

  closing_checker chk = new();

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still pending", cycles, chk.pending());
      $display("tb_binary_closing_diamond5: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) chk.take_item(in_data);
    if (rst_n && out_valid && out_ready) chk.check_pixel(out_data);
  end

  // receiver stalls: mostly short runs, some long free stretches, some longer stalls
  initial begin
    int sel;
    int run;
    logic lvl;
    @(posedge rst_n);
    forever begin
      sel = $urandom_range(0, 19);
      if (sel < 3) begin
        run = $urandom_range(20, 200);
        lvl = 1'b1;
      end else if (sel < 18) begin
        run = $urandom_range(1, 4);
        lvl = $urandom_range(0, 1);
      end else begin
        run = $urandom_range(10, 30);
        lvl = 1'b0;
      end
      repeat (run) begin
        @(negedge clk);
        out_ready <= lvl;
      end
    end
  end

  function automatic int pick_gap();
    int sel;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      burst_left = $urandom_range(20, 120);
      return 0;
    end
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // leaves time at a negedge, after the model has seen the last accepted item
  task automatic hold_gap();
    int gap;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_data  <= in_item_t'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drive(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [7:0] pick_level(int fg_pct);
    int sel;
    int thr;
    thr = chk.thr;
    sel = $urandom_range(0, 99);
    if (sel < 4) return thr;
    if (sel < 8) return (thr == 255) ? 8'd255 : thr + 1;
    if ($urandom_range(0, 99) < fg_pct || thr == 255) return $urandom_range(0, thr);
    return $urandom_range(thr + 1, 255);
  endfunction

  // n items that move the frame position; flushes inside the frame and
  // pixels in the tail are mixed in as noise
  task automatic send_items(longint n);
    in_item_t it;
    longint   pos;
    int       fg_pct;
    fg_pct = $urandom_range(0, 100);
    while (n > 0) begin
      hold_gap();
      pos = chk.frame_pos();
      if (pos == 0) fg_pct = $urandom_range(0, $urandom_range(0, 1) ? 30 : 100);
      it.pixel_in = $urandom_range(0, 255);
      if (pos < chk.frame_total()) begin
        if ($urandom_range(0, 99) < 4) begin
          it.command = CMD_FLUSH;
        end else begin
          it.command  = CMD_PIXEL;
          it.pixel_in = pick_level(fg_pct);
          n--;
        end
      end else begin
        it.command = ($urandom_range(0, 99) < 6) ? CMD_PIXEL : CMD_FLUSH;
        n--;
      end
      drive(it);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk.pending() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic read_reg(logic [1:0] idx, logic [31:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want)
      chk.flag($sformatf("register %0d reads 0x%0h, want 0x%0h", idx, prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value, logic [31:0] mask);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    chk.set_register(idx, value);
    n_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    read_reg(idx, value & mask);
  endtask

  task automatic set_threshold(int thr);
    write_reg(REG_THRESHOLD, thr, 32'h0ff);
  endtask

  task automatic set_geometry(int w, int h);
    write_reg(REG_FRAME_WIDTH, w, 32'h7ff);
    write_reg(REG_FRAME_HEIGHT, h, 32'h7ff);
  endtask

  task automatic run_frames(int thr, int w, int h, int frames);
    settle();
    set_threshold(thr);
    set_geometry(w, h);
    send_items(frames * chk.frame_span());
  endtask

  function automatic int pick_threshold();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 0;
    if (sel == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  initial begin
    logic [7:0] levels [9] = '{8'd0, 8'd255, 8'd128, 8'd129, 8'd127,
                               8'd0, 8'd255, 8'h55, 8'haa};
    longint     start;
    longint     rest;
    int         w;
    int         h;
    int         sel;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    burst_left = 0;
    n_writes   = 0;
    cycles     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    read_reg(REG_THRESHOLD, THRESHOLD_RST);
    read_reg(REG_FRAME_WIDTH, FRAME_WIDTH_RST);
    read_reg(REG_FRAME_HEIGHT, FRAME_HEIGHT_RST);

    // directed 3x3 frame: level extremes, threshold boundary, a flush
    // inside the frame and a pixel sent during the tail
    set_threshold(128);
    set_geometry(3, 3);
    for (int i = 0; i < 9; i++) begin
      if (i == 6) begin
        hold_gap();
        drive(in_item_t'{CMD_FLUSH, 8'h5a});
      end
      hold_gap();
      drive(in_item_t'{CMD_PIXEL, levels[i]});
    end
    for (int i = 0; i < 16; i++) begin
      hold_gap();
      drive(in_item_t'{(i == 7) ? CMD_PIXEL : CMD_FLUSH, 8'($urandom)});
    end

    // geometry and threshold extremes, out-of-range sizes clamp
    run_frames(0, 1, 1, 2);
    run_frames(255, 0, 2047, 1);
    run_frames($urandom_range(1, 254), 2047, 1, 1);
    run_frames(pick_threshold(), 2, 2, 3);

    start = chk.n_items;
    while (chk.n_items - start < RANDOM_ITEMS) begin
      settle();
      // mid-frame: either restart through a geometry write or keep going
      if ($urandom_range(0, 9) < (chk.frame_pos() != 0 ? 4 : 7)) begin
        sel = $urandom_range(0, 19);
        w   = (sel == 0) ? 0 : $urandom_range(1, (sel < 16) ? 12 : 40);
        h   = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
        set_geometry(w, h);
        if ($urandom_range(0, 1)) set_threshold(pick_threshold());
      end else begin
        set_threshold(pick_threshold());
      end
      rest = chk.frame_span() - chk.frame_pos();
      if ($urandom_range(0, 4) == 0) send_items($urandom_range(1, int'(rest)));
      else send_items(rest + $urandom_range(0, 2) * chk.frame_span());
    end
    settle();
    if (chk.frame_pos() != 0) send_items(chk.frame_span() - chk.frame_pos());
    settle();

    $display("covered %0d input items, %0d output items over %0d frames, %0d register writes",
             chk.n_items, chk.n_results, chk.n_frames, n_writes);
    if (chk.errors == 0) begin
      $display("tb_binary_closing_diamond5: clean");
    end else begin
      $display("%0d mismatches", chk.errors);
      $display("tb_binary_closing_diamond5: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bcd5_pkg.sv
hw/rtl/binary_closing_diamond5.sv
hw/rtl/bcd5_checker.sv
sim/tb_binary_closing_diamond5.sv
